// ===== src/pcie_pkg.sv =====
`default_nettype none
package pcie_pkg;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    localparam logic [2:0] K_VD = 3'd0;
    localparam logic [2:0] K_DD = 3'd1;
    localparam logic [2:0] K_DV = 3'd2;
    localparam logic [2:0] K_EE = 3'd3;
    localparam logic [2:0] K_ED = 3'd4;
    localparam logic [2:0] K_DE = 3'd5;

    localparam logic [3:0] F_WEIGHT = 4'd1;
    localparam logic [3:0] F_EMPTY  = 4'd2;
    localparam logic [3:0] F_NOBALL = 4'd4;
    localparam logic [3:0] F_DIVZ   = 4'd8;

    // one cell clip job handed from the front to the back
    typedef struct packed {
        logic               is_status;
        logic               last;
        logic [11:0]        cidx;
        logic signed [31:0] xc;
        logic signed [31:0] we;
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic [3:0]         flags;
    } t_job;

    // one result word
    typedef struct packed {
        logic               is_status;
        logic [11:0]        cidx;
        logic [2:0]         k0;
        logic [2:0]         k1;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic [3:0]         flags;
        logic               last;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v < 35'(Q_MIN)) return Q_MIN;
        if (v > 35'(Q_MAX)) return Q_MAX;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== src/pcie_div.sv =====
`default_nettype none
// restoring divider, one quotient bit a cycle, truncation toward zero
module pcie_div
    import pcie_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [48:0]  i_num,
    input  wire signed [32:0]  i_den,
    output logic               o_done,
    output logic signed [49:0] o_quo
);
    logic [48:0] r_q;
    logic [49:0] r_rem;
    logic [32:0] r_den;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [49:0] w_sh;
    logic [49:0] w_sub;

    assign w_sh  = {r_rem[48:0], r_q[48]};
    assign w_sub = w_sh - {17'd0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd49;
                r_q    <= i_num[48] ? 49'(-i_num) : i_num;
                r_den  <= i_den[32] ? 33'(-i_den) : i_den;
                r_neg  <= i_num[48] ^ i_den[32];
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_sub[49]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[47:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[47:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
endmodule
`default_nettype wire

// ===== src/pcie_sqrt.sv =====
`default_nettype none
// bit-pair integer square root, one result bit a cycle
module pcie_sqrt (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_v;
    logic [65:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [65:0] w_tr;
    logic [65:0] w_sub;

    assign w_tr  = {r_rem[63:0], r_v[63:62]};
    assign w_sub = w_tr - {32'd0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_v    <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v <= {r_v[61:0], 2'b00};
                if (!w_sub[65]) begin
                    r_rem  <= w_sub;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_tr;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== src/pcie_front.sv =====
`default_nettype none
// boundary computation and per-site bookkeeping, one site at a time
module pcie_front
    import pcie_pkg::*;
#(
    parameter int MAX_CELLS = 4096
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_pos,
    input  wire signed [31:0]  i_w,
    input  wire                i_fin,
    output logic               o_job_valid,
    input  wire                i_job_ready,
    output t_job               o_job
);
    localparam int CW = $clog2(MAX_CELLS);
    localparam logic [CW-1:0] CMAX = CW'(MAX_CELLS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_J1   = 3'd2;
    localparam logic [2:0] S_J2   = 3'd3;
    localparam logic [2:0] S_J3   = 3'd4;

    logic [2:0]         r_st;
    logic signed [31:0] r_pos, r_w, r_ppos, r_pw, r_pb, r_c1;
    logic               r_fin, r_have, r_halt;
    logic [CW-1:0]      r_cnt;
    logic               r_div_go;
    logic               w_div_done;
    logic signed [49:0] w_quo;
    logic signed [50:0] w_sum;
    logic signed [50:0] w_half;
    logic signed [31:0] w_c1;
    logic [11:0]        w_cell;

    pcie_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_go),
        .i_num(49'(($signed({r_w[31], r_w}) - $signed({r_pw[31], r_pw}))) <<< 16),
        .i_den(33'($signed({r_pos[31], r_pos}) - $signed({r_ppos[31], r_ppos}))),
        .o_done(w_div_done), .o_quo(w_quo)
    );

    assign w_sum  = 51'(r_pos) + 51'(r_ppos) - 51'(w_quo);
    assign w_half = (w_sum + (w_sum[50] ? 51'sd1 : 51'sd0)) >>> 1;
    // boundary saturated from the full-width half sum
    assign w_c1   = (w_half > 51'(Q_MAX)) ? Q_MAX :
                    (w_half < 51'(Q_MIN)) ? Q_MIN : w_half[31:0];
    assign w_cell = 12'(r_cnt);
    assign o_ready = (r_st == S_IDLE);

    always_comb begin
        o_job_valid = 1'b0;
        o_job = '0;
        o_job.cidx = w_cell;
        case (r_st)
            S_J1: begin
                o_job_valid = 1'b1;
                o_job.last = !r_fin;
                o_job.xc = r_ppos; o_job.we = r_pw; o_job.c0 = r_pb; o_job.c1 = r_c1;
            end
            S_J2: begin
                o_job_valid = 1'b1;
                o_job.xc = r_pos; o_job.we = r_w; o_job.c0 = r_pb; o_job.c1 = Q_MAX;
            end
            S_J3: begin
                o_job_valid = 1'b1;
                o_job.is_status = 1'b1;
                o_job.last = 1'b1;
                o_job.flags = r_halt ? F_DIVZ : 4'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_have <= 1'b0; r_halt <= 1'b0; r_cnt <= '0;
            r_ppos <= '0; r_pw <= '0; r_pb <= Q_MIN; r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_pos <= i_pos; r_w <= i_w; r_fin <= i_fin;
                    if (r_halt) begin
                        r_st <= i_fin ? S_J3 : S_IDLE;
                    end else if (r_have && i_pos == r_ppos) begin
                        r_halt <= 1'b1;
                        r_st <= i_fin ? S_J3 : S_IDLE;
                    end else if (r_have) begin
                        r_div_go <= 1'b1;
                        r_st <= S_DIV;
                    end else begin
                        r_ppos <= i_pos; r_pw <= i_w; r_have <= 1'b1;
                        r_st <= i_fin ? S_J2 : S_IDLE;
                    end
                end
                S_DIV: if (w_div_done) begin
                    r_c1 <= w_c1;
                    r_st <= S_J1;
                end
                S_J1: if (i_job_ready) begin
                    r_pb <= r_c1; r_ppos <= r_pos; r_pw <= r_w;
                    if (r_cnt != CMAX) r_cnt <= r_cnt + 1'b1;
                    r_st <= r_fin ? S_J2 : S_IDLE;
                end
                S_J2: if (i_job_ready) r_st <= S_J3;
                S_J3: if (i_job_ready) begin
                    r_st <= S_IDLE; r_have <= 1'b0; r_halt <= 1'b0; r_cnt <= '0;
                    r_ppos <= '0; r_pw <= '0; r_pb <= Q_MIN;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/pcie_back.sv =====
`default_nettype none
// clips one cell against ball and cut ball, emits sub-intervals and status
module pcie_back
    import pcie_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [30:0] i_eps,
    input  wire         i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  wire         i_ready,
    output t_res        o_res
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RB   = 3'd1;
    localparam logic [2:0] S_RE   = 3'd2;
    localparam logic [2:0] S_PLAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]         r_st;
    t_job               r_job;
    logic [3:0]         r_err;
    logic signed [33:0] r_b0, r_b1, r_e0, r_e1;
    logic               r_cut;
    logic [63:0]        r_wq;
    logic [61:0]        r_ee;
    logic               r_sq_go;
    logic               w_sq_done;
    logic [31:0]        w_root;
    logic signed [33:0] w_lo, w_hi;
    // up to three planned intervals
    logic [1:0]         r_n, r_i;
    logic [2:0]         r_k0 [3];
    logic [2:0]         r_k1 [3];
    logic signed [33:0] r_x0 [3];
    logic signed [33:0] r_x1 [3];
    logic [1:0]         n_n;
    logic [2:0]         n_k0 [3];
    logic [2:0]         n_k1 [3];
    logic signed [33:0] n_x0 [3];
    logic signed [33:0] n_x1 [3];
    logic signed [33:0] c0, c1;

    pcie_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_sq_go),
        .i_val((r_st == S_IDLE || r_st == S_RB) && !r_cut ? r_wq : r_wq - 64'(r_ee)),
        .o_done(w_sq_done), .o_root(w_root)
    );

    assign c0 = 34'(r_job.c0);
    assign c1 = 34'(r_job.c1);
    // center minus and plus the current root, signed
    assign w_lo = 34'($signed(r_job.xc)) - $signed(34'(w_root));
    assign w_hi = 34'($signed(r_job.xc)) + $signed(34'(w_root));

    always_comb begin
        n_n = '0;
        for (int k = 0; k < 3; k++) begin
            n_k0[k] = K_DD; n_k1[k] = K_DD; n_x0[k] = c0; n_x1[k] = c1;
        end
        if (r_cut) begin
            if (c0 > r_e1) begin
                n_n = 2'd1; n_x0[0] = c0;
                if (c1 < r_b1) n_x1[0] = c1;
                else begin n_k1[0] = K_DV; n_x1[0] = r_b1; end
            end else if (c0 > r_e0) begin
                n_k0[0] = K_EE; n_x0[0] = c0;
                if (c1 < r_e1) begin
                    n_n = 2'd1; n_k1[0] = K_EE; n_x1[0] = c1;
                end else begin
                    n_n = 2'd2; n_k1[0] = K_ED; n_x1[0] = r_e1;
                    n_k0[1] = K_ED; n_x0[1] = r_e1;
                    if (c1 < r_b1) begin n_k1[1] = K_DD; n_x1[1] = c1; end
                    else begin n_k1[1] = K_DV; n_x1[1] = r_b1; end
                end
            end else begin
                n_k0[0] = (c0 > r_b0) ? K_DD : K_VD;
                n_x0[0] = (c0 > r_b0) ? c0 : r_b0;
                if (c1 < r_e0) begin
                    n_n = 2'd1; n_k1[0] = (c0 > r_b0) ? K_DE : K_DD; n_x1[0] = c1;
                end else begin
                    n_k1[0] = K_DE; n_x1[0] = r_e0;
                    n_k0[1] = K_DE; n_x0[1] = r_e0;
                    if (c1 < r_e1) begin
                        n_n = 2'd2; n_k1[1] = K_EE; n_x1[1] = c1;
                    end else begin
                        n_n = 2'd3; n_k1[1] = K_ED; n_x1[1] = r_e1;
                        n_k0[2] = K_ED; n_x0[2] = r_e1;
                        if (c1 < r_b1) begin n_k1[2] = K_DD; n_x1[2] = c1; end
                        else begin n_k1[2] = K_DV; n_x1[2] = r_b1; end
                    end
                end
            end
        end else begin
            n_n = 2'd1;
            if (c0 < r_b0) begin n_k0[0] = K_VD; n_x0[0] = r_b0; end
            if (c1 > r_b1) begin n_k1[0] = K_DV; n_x1[0] = r_b1; end
        end
    end

    assign o_job_ready = (r_st == S_IDLE);

    always_comb begin
        o_valid = (r_st == S_EMIT);
        o_res = '0;
        o_res.cidx = r_job.cidx;
        if (r_job.is_status) begin
            o_res.is_status = 1'b1;
            o_res.flags = r_err;
            o_res.last = 1'b1;
        end else begin
            o_res.k0 = r_k0[r_i];
            o_res.k1 = r_k1[r_i];
            o_res.x0 = sat32(35'(r_x0[r_i]));
            o_res.x1 = sat32(35'(r_x1[r_i]));
            o_res.last = r_job.last && (r_i + 2'd1 == r_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_err <= '0; r_sq_go <= 1'b0; r_cut <= 1'b0;
        end else begin
            r_sq_go <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_job <= i_job;
                    r_cut <= 1'b0;
                    r_wq  <= {i_job.we[31:0], 16'd0, 16'd0} >> 16;
                    r_ee  <= 62'(i_eps) * 62'(i_eps);
                    if (i_job.is_status) begin
                        // a halted set reports division by zero alone
                        if (i_job.flags == F_DIVZ) r_err <= F_DIVZ;
                        r_st <= S_EMIT;
                    end
                    else if (i_job.c0 >= i_job.c1) r_err <= r_err | F_EMPTY;
                    else if (i_job.we <= 0) r_err <= r_err | F_WEIGHT;
                    else begin r_sq_go <= 1'b1; r_st <= S_RB; end
                end
                S_RB: if (w_sq_done) begin
                    r_b0 <= w_lo;
                    r_b1 <= w_hi;
                    if (c0 >= w_hi || c1 <= w_lo) begin
                        r_err <= r_err | F_NOBALL; r_st <= S_IDLE;
                    end else if (32'(i_eps) < w_root) begin
                        r_cut <= 1'b1; r_sq_go <= 1'b1; r_st <= S_RE;
                    end else r_st <= S_PLAN;
                end
                S_RE: if (w_sq_done) begin
                    r_e0 <= w_lo;
                    r_e1 <= w_hi;
                    r_st <= S_PLAN;
                end
                S_PLAN: begin
                    r_n <= n_n; r_i <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_k0[k] <= n_k0[k]; r_k1[k] <= n_k1[k];
                        r_x0[k] <= n_x0[k]; r_x1[k] <= n_x1[k];
                    end
                    r_st <= S_EMIT;
                end
                S_EMIT: if (i_ready) begin
                    if (r_job.is_status) begin
                        r_err <= '0; r_st <= S_IDLE;
                    end else if (r_i + 2'd1 == r_n) r_st <= S_IDLE;
                    else r_i <= r_i + 2'd1;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/pcie_out.sv =====
`default_nettype none
// registered output stage, one word deep
module pcie_out
    import pcie_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_res  i_res,
    output logic  o_valid,
    input  wire   i_ready,
    output t_res  o_res
);
    logic r_full;
    t_res r_res;
    assign o_ready = !r_full || i_ready;
    assign o_valid = r_full;
    assign o_res = r_res;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_full <= 1'b0;
        else if (o_ready) begin
            r_full <= i_valid;
            if (i_valid) r_res <= i_res;
        end
    end
endmodule
`default_nettype wire

// ===== src/power_cell_interval_emitter.sv =====
`default_nettype none
// Power-diagram cell interval emitter for sorted, merged 1-D sites. Each site word
// is held by the front end, which computes the boundary to the previous site with a
// 49-step serial divider; a site with a predecessor passes from accept through
// divider start, the divider steps, done, job hand-off and idle to the next accept.
// The back end clips the cell span against the sqrt(weight) ball and the
// epsilon-cut ball with a 32-step serial square root, run once for the ball alone
// and once more when the cut ball applies, and emits up to three interval words.
// The front stalls on the back. A final site adds its own cell and one status word.
// Division by zero halts emission until the final site. Each job carries a flag
// that marks the last job of its input, so last_of_run lands on the last word.
module power_cell_interval_emitter
    import pcie_pkg::*;
#(
    parameter int MAX_CELLS = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [31:0] i_cfg_data,   // eps_height in bits 30:0
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata, // site_position, site_weight
    input  wire         s_axis_tlast, // final_site
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [87:0] m_axis_tdata, // cell_index, start_kind, end_kind, start_x, end_x,
                                      // error_flags
    output logic        m_axis_tlast, // last_of_run
    output logic        m_axis_tuser  // is_status
);
    logic [30:0] r_eps;
    logic        w_jv, w_jr, w_bv, w_br;
    t_job        w_job;
    t_res        w_bres, w_ores;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= 31'd6554;
        else if (i_cfg_valid) r_eps <= i_cfg_data[30:0];
    end

    pcie_front #(.MAX_CELLS(MAX_CELLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_pos(s_axis_tdata[31:0]), .i_w(s_axis_tdata[63:32]), .i_fin(s_axis_tlast),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    pcie_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_eps(r_eps),
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .o_valid(w_bv), .i_ready(w_br), .o_res(w_bres)
    );

    pcie_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_bv), .o_ready(w_br), .i_res(w_bres),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_ores)
    );

    assign m_axis_tdata = {2'd0, w_ores.flags, w_ores.x1, w_ores.x0,
                           w_ores.k1, w_ores.k0, w_ores.cidx};
    assign m_axis_tlast = w_ores.last;
    assign m_axis_tuser = w_ores.is_status;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;
    import pcie_pkg::*;

    typedef struct {
        logic        is_status;
        logic [11:0] cidx;
        logic [2:0]  k0;
        logic [2:0]  k1;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [3:0]  flags;
        logic        last;
    } cell_word_t;

    localparam int      CELL_CAP = 4096;
    localparam longint  QLO = -64'sd2147483648;
    localparam longint  QHI = 64'sd2147483647;

    // interval predictor plus queue of expected words
    class cell_board;
        cell_word_t pending[$];
        int         errors;
        longint     eps;
        longint     ppos, pw, pbound;
        bit         have_prev, halted;
        int         cnt;
        logic [3:0] accum;

        function new();
            errors = 0;
            eps = 6554;
            clear_set();
        endfunction

        function void clear_set();
            ppos = 0; pw = 0; pbound = QLO;
            have_prev = 0; halted = 0; cnt = 0; accum = 0;
        endfunction

        function longint sat(longint v);
            if (v < QLO) return QLO;
            if (v > QHI) return QHI;
            return v;
        endfunction

        function longint root(longint v);
            longint r, b;
            r = 0; b = 64'sd1 <<< 62;
            while (b > v) b = b >>> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end else begin
                    r = r >>> 1;
                end
                b = b >>> 2;
            end
            return r;
        endfunction

        function void push(logic [2:0] k0, logic [2:0] k1, longint x0, longint x1);
            cell_word_t w;
            w.is_status = 0; w.cidx = cnt[11:0]; w.k0 = k0; w.k1 = k1;
            w.x0 = sat(x0); w.x1 = sat(x1); w.flags = 0; w.last = 0;
            pending = {pending, w};
        endfunction

        // clip one cell span against the ball and the eps-cut ball
        function void clip(longint xc, longint we, longint c0, longint c1);
            longint rb, b0, b1, re, e0, e1;
            if (c0 >= c1) begin accum |= F_EMPTY; return; end
            if (we <= 0) begin accum |= F_WEIGHT; return; end
            rb = root(we * 65536);
            b0 = xc - rb; b1 = xc + rb;
            if (c0 >= b1 || c1 <= b0) begin accum |= F_NOBALL; return; end
            if (eps < rb) begin
                re = root(we * 65536 - eps * eps);
                e0 = xc - re; e1 = xc + re;
                if (c0 > e1) begin
                    if (c1 < b1) push(K_DD, K_DD, c0, c1);
                    else push(K_DD, K_DV, c0, b1);
                    return;
                end
                if (c0 > e0) begin
                    if (c1 < e1) begin push(K_EE, K_EE, c0, c1); return; end
                    push(K_EE, K_ED, c0, e1);
                    if (c1 < b1) push(K_ED, K_DD, e1, c1);
                    else push(K_ED, K_DV, e1, b1);
                    return;
                end
                if (c0 > b0) begin
                    if (c1 < e0) begin push(K_DD, K_DE, c0, c1); return; end
                    push(K_DD, K_DE, c0, e0);
                end else begin
                    if (c1 < e0) begin push(K_VD, K_DD, b0, c1); return; end
                    push(K_VD, K_DE, b0, e0);
                end
                if (c1 < e1) begin push(K_DE, K_EE, e0, c1); return; end
                push(K_DE, K_ED, e0, e1);
                if (c1 < b1) push(K_ED, K_DD, e1, c1);
                else push(K_ED, K_DV, e1, b1);
                return;
            end
            if (c0 < b0) begin
                if (c1 > b1) push(K_VD, K_DV, b0, b1);
                else push(K_VD, K_DD, b0, c1);
            end else if (c1 > b1) push(K_DD, K_DV, c0, b1);
            else push(K_DD, K_DD, c0, c1);
        endfunction

        function void note_site(logic [31:0] p, logic [31:0] w, bit fin);
            longint pos, wt, dd, q, c1;
            int n0;
            cell_word_t s;
            pos = longint'($signed(p)); wt = longint'($signed(w));
            n0 = pending.size();
            if (!halted) begin
                if (have_prev) begin
                    dd = pos - ppos;
                    if (dd == 0) begin
                        halted = 1; accum = F_DIVZ;
                    end else begin
                        q = ((wt - pw) * 65536) / dd;
                        c1 = sat((pos + ppos - q) / 2);
                        clip(ppos, pw, pbound, c1);
                        pbound = c1;
                        if (cnt < CELL_CAP - 1) cnt++;
                    end
                end
                if (!halted) begin
                    ppos = pos; pw = wt; have_prev = 1;
                    if (fin) clip(ppos, pw, pbound, QHI);
                end
            end
            if (fin) begin
                s.is_status = 1; s.cidx = cnt[11:0]; s.k0 = 0; s.k1 = 0;
                s.x0 = 0; s.x1 = 0; s.flags = accum; s.last = 0;
                pending = {pending, s};
                clear_set();
            end
            if (pending.size() > n0) pending[$].last = 1;
        endfunction

        function void check_word(cell_word_t got);
            cell_word_t e;
            if (pending.size() == 0) begin
                $error("unexpected word cell_index=%0d", got.cidx);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.is_status !== e.is_status) begin
                $error("is_status exp %0d got %0d", e.is_status, got.is_status); errors++; end
            if (got.cidx !== e.cidx) begin
                $error("cell_index exp %0d got %0d", e.cidx, got.cidx); errors++; end
            if (got.k0 !== e.k0) begin
                $error("start_kind exp %0d got %0d", e.k0, got.k0); errors++; end
            if (got.k1 !== e.k1) begin
                $error("end_kind exp %0d got %0d", e.k1, got.k1); errors++; end
            if (got.x0 !== e.x0) begin
                $error("start_x exp %h got %h", e.x0, got.x0); errors++; end
            if (got.x1 !== e.x1) begin
                $error("end_x exp %h got %h", e.x1, got.x1); errors++; end
            if (got.flags !== e.flags) begin
                $error("error_flags exp %h got %h", e.flags, got.flags); errors++; end
            if (got.last !== e.last) begin
                $error("last_of_run exp %0d got %0d", e.last, got.last); errors++; end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [31:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic [63:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tready = 0;
    wire         o_cfg_ready, s_axis_tready, m_axis_tvalid, m_axis_tlast, m_axis_tuser;
    wire  [87:0] m_axis_tdata;

    cell_board board = new();
    bit          quiet = 0;   // no idling near the end
    int          n_sent = 0;

    always #1 i_clk = ~i_clk;

    power_cell_interval_emitter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    // result side: random stall bursts, check every accepted word
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(19, 1) : 0;
            m_axis_tready <= (gap == 0);
            if (gap == 0) @(posedge i_clk);
            else repeat (gap) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        cell_word_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.cidx = m_axis_tdata[11:0];
            got.k0 = m_axis_tdata[14:12];
            got.k1 = m_axis_tdata[17:15];
            got.x0 = m_axis_tdata[49:18];
            got.x1 = m_axis_tdata[81:50];
            got.flags = m_axis_tdata[85:82];
            got.is_status = m_axis_tuser;
            got.last = m_axis_tlast;
            board.check_word(got);
        end
    end

    task automatic send_site(logic [31:0] p, logic [31:0] w, bit fin);
        int gap;
        gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(19, 1) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {w, p};
        s_axis_tlast <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_site(p, w, fin);
        n_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        // block may still be clipping a cell that emits nothing
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [30:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= {1'b0, v};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        board.eps = v;
        @(posedge i_clk);
    endtask

    // a random set: non-decreasing positions, mostly positive weights
    task automatic random_set(int n);
        logic [31:0] p, w;
        int step;
        p = $urandom_range(3) == 0 ? $urandom : -($urandom_range(20, 0) << 16);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: w = $urandom;
                1: w = 0;
                default: w = $urandom_range(32'h0008_0000, 1);
            endcase
            send_site(p, w, i == n - 1);
            step = $urandom_range(15) == 0 ? 0 : $urandom_range(32'h0004_0000, 1);
            if ($signed(p) > $signed(32'h7000_0000)) step = 1;
            p = p + step;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, single site, division by zero, huge weights
        send_site(32'h0000_0000, 32'h0001_0000, 1);
        send_site(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_site(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_site(32'h0000_0000, 32'h8000_0000, 0);
        send_site(32'h0001_0000, 32'hFFFF_FFFF, 1);
        send_site(32'h0000_0000, 32'h0004_0000, 0);
        send_site(32'h0000_0000, 32'h0004_0000, 0);
        send_site(32'h0002_0000, 32'h0001_0000, 0);
        send_site(32'h0003_0000, 32'h0001_0000, 1);
        send_site(32'h0000_0000, 32'h0001_0000, 0);
        send_site(32'h0000_8000, 32'h0040_0000, 0);
        send_site(32'h0010_0000, 32'h0000_1000, 0);
        send_site(32'h0010_1000, 32'h0000_1000, 1);
        send_site(32'hFFFF_0000, 32'h0000_0001, 0);
        send_site(32'h0000_0000, 32'h0002_0000, 1);
        drain();

        write_eps(31'h7FFF_FFFF);
        random_set(4);
        drain();
        write_eps(0);
        random_set(3);
        random_set(1);
        drain();
        write_eps(31'h0000_8000);
        random_set(5);
        drain();
        write_eps(31'h2AAA_5555);
        random_set(2);
        drain();
        write_eps(31'd6554);

        while (n_sent < 100) begin
            random_set($urandom_range(6, 1));
            if ($urandom_range(4) == 0) begin
                drain();
                write_eps(31'($urandom_range(32'h0002_0000)));
            end
        end
        quiet = 1;
        for (int k = 0; k < 6; k++) random_set($urandom_range(5, 1));
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/pcie_pkg.sv
src/pcie_div.sv
src/pcie_sqrt.sv
src/pcie_front.sv
src/pcie_back.sv
src/pcie_out.sv
src/power_cell_interval_emitter.sv
verif/tb.sv
